/* rtl/qrenc_pkg.sv */
package qrenc_pkg;

  localparam int MAX_CHARS  = 25;
  localparam int SIDE       = 21;
  localparam int HDR_BITS   = 13;
  localparam int DATA_BYTES = 19;
  localparam int ECC_BYTES  = 7;
  localparam int DATA_BITS  = 152;
  localparam int CW_BITS    = 208;
  localparam int ALNUM_BASE = 45;

  localparam logic [3:0]  MODE_ALNUM = 4'b0010;
  localparam logic [7:0]  PAD_A      = 8'hEC;
  localparam logic [7:0]  PAD_B      = 8'h11;
  localparam logic [7:0]  GF_POLY    = 8'h1D;
  localparam logic [10:0] FMT_POLY   = 11'h537;
  localparam logic [14:0] FMT_MASK   = 15'h5412;
  localparam logic [14:0] FMT_ECC_L  = 15'h2000;
  localparam logic [10:0] FMT_SEED   = 11'd8;

  localparam logic [7:0] GEN [ECC_BYTES] = '{8'd127, 8'd122, 8'd154, 8'd164,
                                            8'd11, 8'd68, 8'd117};

  typedef logic [SIDE-1:0] row_t;
  typedef row_t [SIDE-1:0] grid_t;

  typedef struct packed {
    logic accept;
    logic load_pend;
    logic push_step;
    logic hdr;
    logic pad_step;
    logic rs_start;
    logic rs_step;
    logic pl_step;
    logic out_start;
    logic out_adv;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic pair_start;
    logic push_last;
    logic err;
    logic pend;
    logic pad_done;
    logic rs_last;
    logic pl_last;
    logic row_last;
  } sts_t;

  // {valid, code}
  function automatic logic [6:0] alnum_code(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      r = {1'b1, t[5:0]};
    end else if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h37;
      r = {1'b1, t[5:0]};
    end else begin
      case (c)
        8'h20:   r = {1'b1, 6'd36};
        8'h24:   r = {1'b1, 6'd37};
        8'h25:   r = {1'b1, 6'd38};
        8'h2A:   r = {1'b1, 6'd39};
        8'h2B:   r = {1'b1, 6'd40};
        8'h2D:   r = {1'b1, 6'd41};
        8'h2E:   r = {1'b1, 6'd42};
        8'h2F:   r = {1'b1, 6'd43};
        8'h3A:   r = {1'b1, 6'd44};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] aa;
    logic [7:0] bb;
    r  = '0;
    aa = a;
    bb = b;
    for (int i = 0; i < 8; i++) begin
      if (bb[0]) r = r ^ aa;
      aa = aa[7] ? ({aa[6:0], 1'b0} ^ GF_POLY) : {aa[6:0], 1'b0};
      bb = bb >> 1;
    end
    return r;
  endfunction

  // Finder, timing and format modules; returns the dark pattern or the occupancy map
  function automatic grid_t fixed_grid(input logic want_map);
    grid_t dk;
    grid_t mp;
    int x, y, ax, ay, d, cx, cy;
    logic [10:0] rem;
    logic [14:0] fmt;
    dk = '0;
    mp = '0;
    for (int i = 0; i < SIDE; i++) begin
      dk[i][6] = ((i & 1) == 0);
      mp[i][6] = 1'b1;
      dk[6][i] = ((i & 1) == 0);
      mp[6][i] = 1'b1;
    end
    for (int e = 0; e < 3; e++) begin
      cx = (e == 1) ? SIDE - 4 : 3;
      cy = (e == 2) ? SIDE - 4 : 3;
      for (int dy = -4; dy <= 4; dy++) begin
        for (int dx = -4; dx <= 4; dx++) begin
          x  = cx + dx;
          y  = cy + dy;
          ax = (dx < 0) ? -dx : dx;
          ay = (dy < 0) ? -dy : dy;
          d  = (ax > ay) ? ax : ay;
          if (x >= 0 && y >= 0 && x < SIDE && y < SIDE) begin
            dk[y][x] = (d != 2) && (d != 4);
            mp[y][x] = 1'b1;
          end
        end
      end
    end
    rem = FMT_SEED;
    for (int i = 0; i < 10; i++) begin
      rem = {rem[9:0], 1'b0} ^ (rem[9] ? FMT_POLY : 11'd0);
    end
    fmt = (FMT_ECC_L | {4'b0000, rem}) ^ FMT_MASK;
    for (int i = 0; i <= 5; i++) begin
      dk[i][8] = fmt[i];
      mp[i][8] = 1'b1;
    end
    dk[7][8] = fmt[6];
    mp[7][8] = 1'b1;
    dk[8][8] = fmt[7];
    mp[8][8] = 1'b1;
    dk[8][7] = fmt[8];
    mp[8][7] = 1'b1;
    for (int i = 9; i < 15; i++) begin
      dk[8][14-i] = fmt[i];
      mp[8][14-i] = 1'b1;
    end
    for (int i = 0; i < 8; i++) begin
      dk[8][SIDE-1-i] = fmt[i];
      mp[8][SIDE-1-i] = 1'b1;
    end
    for (int i = 8; i < 15; i++) begin
      dk[SIDE-15+i][8] = fmt[i];
      mp[SIDE-15+i][8] = 1'b1;
    end
    dk[SIDE-8][8] = 1'b1;
    mp[SIDE-8][8] = 1'b1;
    return want_map ? mp : dk;
  endfunction

  localparam grid_t FIX_DARK = fixed_grid(1'b0);
  localparam grid_t FIX_MAP  = fixed_grid(1'b1);

endpackage

/* rtl/qrenc_ctrl.sv */
module qrenc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              s_last_i,
  input  logic              m_ready_i,
  input  qrenc_pkg::sts_t   sts_i,
  output qrenc_pkg::cmd_t   cmd_o,
  output logic              s_ready_o,
  output logic              m_valid_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PUSH  = 8'b0000_0010,
    ST_FIN   = 8'b0000_0100,
    ST_HDR   = 8'b0000_1000,
    ST_PAD   = 8'b0001_0000,
    ST_RS    = 8'b0010_0000,
    ST_PLACE = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          fin_d        = s_last_i;
          if (sts_i.pair_start) begin
            state_d = ST_PUSH;
          end else if (s_last_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_PUSH: begin
        cmd_o.push_step = 1'b1;
        if (sts_i.push_last) begin
          state_d = fin_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (sts_i.err) begin
          cmd_o.out_start = 1'b1;
          state_d         = ST_OUT;
        end else if (sts_i.pend) begin
          // flush the unpaired character as a 6-bit group
          cmd_o.load_pend = 1'b1;
          state_d         = ST_PUSH;
        end else begin
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        cmd_o.hdr = 1'b1;
        state_d   = ST_PAD;
      end
      ST_PAD: begin
        if (sts_i.pad_done) begin
          cmd_o.rs_start = 1'b1;
          state_d        = ST_RS;
        end else begin
          cmd_o.pad_step = 1'b1;
        end
      end
      ST_RS: begin
        cmd_o.rs_step = 1'b1;
        if (sts_i.rs_last) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        cmd_o.pl_step = 1'b1;
        if (sts_i.pl_last) begin
          cmd_o.out_start = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          if (sts_i.row_last) begin
            cmd_o.clear = 1'b1;
            fin_d       = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            cmd_o.out_adv = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_ready_o && m_valid_o))
    else $error("input and output requests active together");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_ready_i && sts_i.row_last) |=> (state_q == ST_IDLE))
    else $error("controller did not return to idle after the last row");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

/* rtl/qrenc_dp.sv */
module qrenc_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qrenc_pkg::cmd_t  cmd_i,
  input  logic [7:0]       char_i,
  input  logic             has_i,
  output qrenc_pkg::sts_t  sts_o,
  output logic [4:0]       row_idx_o,
  output logic [20:0]      row_bits_o,
  output logic             ok_o,
  output logic             last_row_o
);

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  logic [qrenc_pkg::DATA_BITS-1:0] data_q;
  logic [7:0]  bc_q;
  logic [4:0]  cnt_q;
  logic [5:0]  pend_q;
  logic        pv_q;
  logic        err_q;
  logic [10:0] sh_q;
  logic [3:0]  nb_q;
  logic [4:0]  pad_idx_q;
  logic        pad_sel_q;
  logic [7:0]  chk_q [qrenc_pkg::ECC_BYTES];
  logic [4:0]  rs_idx_q;
  logic [4:0]  right_q;
  logic [4:0]  vert_q;
  logic        k_q;
  logic [7:0]  idx_q;
  logic [4:0]  row_q;
  qrenc_pkg::row_t mat_q [qrenc_pkg::SIDE];

  logic [6:0]  code;
  logic        take, good;
  logic [10:0] pair_val;
  logic [7:0]  pos;
  logic [12:0] hdr;
  logic [7:0]  room, term, align;
  logic [7:0]  fb;
  logic [qrenc_pkg::CW_BITS-1:0] cw;
  logic [4:0]  x, y, rp1;
  logic        up, put, dbit;

  always_comb begin
    code     = qrenc_pkg::alnum_code(char_i);
    take     = cmd_i.accept && has_i && !err_q;
    good     = code[6] && (cnt_q < 5'(qrenc_pkg::MAX_CHARS));
    pair_val = 11'(pend_q) * 11'(qrenc_pkg::ALNUM_BASE) + 11'(code[5:0]);
    pos      = 8'(qrenc_pkg::HDR_BITS) + bc_q;
    hdr      = {qrenc_pkg::MODE_ALNUM, 4'b0000, cnt_q};
    // terminator of up to four zeros, then round up to a byte
    room     = 8'(qrenc_pkg::DATA_BITS) - pos;
    term     = (room < 8'd4) ? room : 8'd4;
    align    = pos + term + 8'd7;
    fb       = rev8(data_q[{rs_idx_q, 3'b000} +: 8]) ^ chk_q[0];

    cw[qrenc_pkg::DATA_BITS-1:0] = data_q;
    for (int j = 0; j < qrenc_pkg::ECC_BYTES; j++) begin
      for (int b = 0; b < 8; b++) begin
        cw[qrenc_pkg::DATA_BITS + 8*j + b] = chk_q[j][7-b];
      end
    end

    x    = right_q - {4'b0000, k_q};
    rp1  = right_q + 5'd1;
    up   = ~rp1[1];
    y    = up ? (5'(qrenc_pkg::SIDE - 1) - vert_q) : vert_q;
    put  = !qrenc_pkg::FIX_MAP[y][x] && (idx_q < 8'(qrenc_pkg::CW_BITS));
    dbit = cw[idx_q] ^ ~(x[0] ^ y[0]);

    sts_o.pair_start = take && good && pv_q;
    sts_o.push_last  = (nb_q == 4'd1);
    sts_o.err        = err_q;
    sts_o.pend       = pv_q;
    sts_o.pad_done   = (pad_idx_q == 5'(qrenc_pkg::DATA_BYTES));
    sts_o.rs_last    = (rs_idx_q == 5'(qrenc_pkg::DATA_BYTES - 1));
    sts_o.pl_last    = k_q && (vert_q == 5'(qrenc_pkg::SIDE - 1)) && (right_q == 5'd1);
    sts_o.row_last   = (row_q == 5'(qrenc_pkg::SIDE - 1));

    row_idx_o  = row_q;
    ok_o       = !err_q;
    last_row_o = sts_o.row_last;
    row_bits_o = err_q ? '0 : ((mat_q[row_q] & ~qrenc_pkg::FIX_MAP[row_q])
                               | qrenc_pkg::FIX_DARK[row_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q    <= '0;
      bc_q      <= '0;
      cnt_q     <= '0;
      pend_q    <= '0;
      pv_q      <= 1'b0;
      err_q     <= 1'b0;
      sh_q      <= '0;
      nb_q      <= '0;
      pad_idx_q <= '0;
      pad_sel_q <= 1'b0;
      for (int j = 0; j < qrenc_pkg::ECC_BYTES; j++) chk_q[j] <= '0;
      rs_idx_q  <= '0;
      right_q   <= '0;
      vert_q    <= '0;
      k_q       <= 1'b0;
      idx_q     <= '0;
      row_q     <= '0;
    end else if (cmd_i.clear) begin
      data_q <= '0;
      bc_q   <= '0;
      cnt_q  <= '0;
      pend_q <= '0;
      pv_q   <= 1'b0;
      err_q  <= 1'b0;
      for (int j = 0; j < qrenc_pkg::ECC_BYTES; j++) chk_q[j] <= '0;
    end else begin
      if (take) begin
        if (!good) begin
          err_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 5'd1;
          if (pv_q) begin
            sh_q   <= pair_val;
            nb_q   <= 4'd11;
            pv_q   <= 1'b0;
            pend_q <= '0;
          end else begin
            pend_q <= code[5:0];
            pv_q   <= 1'b1;
          end
        end
      end
      if (cmd_i.load_pend) begin
        sh_q   <= {pend_q, 5'b00000};
        nb_q   <= 4'd6;
        pv_q   <= 1'b0;
        pend_q <= '0;
      end
      if (cmd_i.push_step) begin
        data_q[pos] <= sh_q[10];
        sh_q        <= {sh_q[9:0], 1'b0};
        bc_q        <= bc_q + 8'd1;
        nb_q        <= nb_q - 4'd1;
      end
      if (cmd_i.hdr) begin
        for (int i = 0; i < qrenc_pkg::HDR_BITS; i++) data_q[i] <= hdr[12-i];
        pad_idx_q <= align[7:3];
        pad_sel_q <= 1'b0;
      end
      if (cmd_i.pad_step) begin
        data_q[{pad_idx_q, 3'b000} +: 8] <= rev8(pad_sel_q ? qrenc_pkg::PAD_B
                                                            : qrenc_pkg::PAD_A);
        pad_idx_q <= pad_idx_q + 5'd1;
        pad_sel_q <= ~pad_sel_q;
      end
      if (cmd_i.rs_start) begin
        for (int j = 0; j < qrenc_pkg::ECC_BYTES; j++) chk_q[j] <= '0;
        rs_idx_q <= '0;
        right_q  <= 5'(qrenc_pkg::SIDE - 1);
        vert_q   <= '0;
        k_q      <= 1'b0;
        idx_q    <= '0;
      end
      if (cmd_i.rs_step) begin
        for (int j = 0; j < qrenc_pkg::ECC_BYTES - 1; j++) begin
          chk_q[j] <= chk_q[j+1] ^ qrenc_pkg::gf_mul(qrenc_pkg::GEN[j], fb);
        end
        chk_q[qrenc_pkg::ECC_BYTES-1] <=
          qrenc_pkg::gf_mul(qrenc_pkg::GEN[qrenc_pkg::ECC_BYTES-1], fb);
        rs_idx_q <= rs_idx_q + 5'd1;
      end
      if (cmd_i.pl_step) begin
        if (put) idx_q <= idx_q + 8'd1;
        if (!k_q) begin
          k_q <= 1'b1;
        end else begin
          k_q <= 1'b0;
          if (vert_q == 5'(qrenc_pkg::SIDE - 1)) begin
            vert_q <= '0;
            // skip the vertical timing column
            right_q <= (right_q == 5'd8) ? 5'd5 : right_q - 5'd2;
          end else begin
            vert_q <= vert_q + 5'd1;
          end
        end
      end
      if (cmd_i.out_start) row_q <= '0;
      if (cmd_i.out_adv)   row_q <= row_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pl_step && put) mat_q[y][x] <= dbit;
  end

  a_bits_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= 8'(qrenc_pkg::DATA_BITS - qrenc_pkg::HDR_BITS))
    else $error("payload overran the data capacity");

  a_chars_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(qrenc_pkg::MAX_CHARS))
    else $error("character count beyond limit");

  a_all_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pl_step && sts_o.pl_last) |=> (idx_q == 8'(qrenc_pkg::CW_BITS)))
    else $error("placement walk did not consume every codeword bit");

endmodule

/* rtl/qr_v1_alnum_symbol_encoder_core.sv */
// QR version 1 alphanumeric encoder (ECC L, mask 0).
// Input stream: one text character per request. tdata carries the ASCII code,
// tuser set means tdata holds a character (clear allows an empty text), tlast
// ends the text. Characters outside the 45-symbol set or beyond 25 flag an error.
// Output stream: 21 requests per text, one per symbol row, top row first;
// tuser is the ok flag and tlast marks row 20. On error every row is zero, ok low.
// Processing: a character is taken on its own request; one that completes a pair
// then has its group shifted into the data buffer one bit per cycle. After tlast
// the block runs the finish step (an unpaired character is flushed as a 6-bit
// group), the header, the pad bytes and the Reed-Solomon pass (one data byte per
// cycle), then walks the zigzag placement (one module per cycle) before the first
// row is offered.
// Input is not taken while a text is being finished or rows are pending.
// Reset clears the text state; the block is ready as soon as reset is released.
// A stalled receiver holds the current row; the block waits without loss.
module qr_v1_alnum_symbol_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tuser_i,   // [0] has_char
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [4:0] row_index, [25:5] row_bits
  output logic        m_axis_tuser_o,   // [0] ok
  output logic        m_axis_tlast_o
);

  qrenc_pkg::cmd_t cmd;
  qrenc_pkg::sts_t sts;
  logic [4:0]  row_idx;
  logic [20:0] row_bits;

  qrenc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o)
  );

  qrenc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .char_i     (s_axis_tdata_i),
    .has_i      (s_axis_tuser_i),
    .sts_o      (sts),
    .row_idx_o  (row_idx),
    .row_bits_o (row_bits),
    .ok_o       (m_axis_tuser_o),
    .last_row_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b000000, row_bits, row_idx};

endmodule

/* sim/qr_v1_alnum_symbol_encoder_core_chk.sv */
module qr_v1_alnum_symbol_encoder_core_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic        m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          fail_cnt_o,
  output int          rows_pending_o
);

  typedef struct packed {
    logic [4:0]  idx;
    logic [20:0] bits;
    logic        ok;
    logic        lst;
  } row_exp_t;

  row_exp_t   row_q[$];
  logic [7:0] text_bytes[qrenc_pkg::DATA_BYTES] = '{default: '0};
  int         nbits = 0, nchars = 0, pend_val = 0;
  logic       pend_vld = 1'b0, bad = 1'b0;
  int         fails = 0, pend_rows = 0;

  assign fail_cnt_o     = fails;
  assign rows_pending_o = pend_rows;

  function automatic int char_symbol(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    case (c)
      " ": return 36;
      "$": return 37;
      "%": return 38;
      "*": return 39;
      "+": return 40;
      "-": return 41;
      ".": return 42;
      "/": return 43;
      ":": return 44;
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1D) : (a << 1);
    end
    return r;
  endfunction

  task automatic put_bit(input int pos, input logic b);
    if (pos < qrenc_pkg::DATA_BITS && b) text_bytes[pos >> 3][7 - (pos & 7)] = 1'b1;
  endtask

  task automatic push_group(input int value, input int n);
    int pos;
    pos = qrenc_pkg::HDR_BITS + nbits;
    if (pos + n > qrenc_pkg::DATA_BITS) begin
      bad = 1;
      return;
    end
    for (int i = n - 1; i >= 0; i--) put_bit(pos + (n - 1 - i), 1'((value >> i) & 1));
    nbits += n;
  endtask

  task automatic clear_text();
    foreach (text_bytes[i]) text_bytes[i] = 0;
    nbits = 0; nchars = 0; pend_val = 0; pend_vld = 0; bad = 0;
  endtask

  task automatic emit_symbol();
    logic [7:0]  cw[qrenc_pkg::DATA_BYTES + qrenc_pkg::ECC_BYTES];
    logic [7:0]  ecc[qrenc_pkg::ECC_BYTES];
    logic [7:0]  pad, f;
    logic [20:0] grid[qrenc_pkg::SIDE];
    logic [20:0] occ[qrenc_pkg::SIDE];
    logic [12:0] hdr;
    int total, term, idx, y, x, right;
    logic d;
    if (pend_vld) push_group(pend_val, 6);
    if (!bad) begin
      hdr = {4'b0010, 9'(nchars)};
      for (int i = 0; i < qrenc_pkg::HDR_BITS; i++)
        put_bit(i, hdr[qrenc_pkg::HDR_BITS - 1 - i]);
      total = qrenc_pkg::HDR_BITS + nbits;
      term = (qrenc_pkg::DATA_BITS - total) < 4 ? qrenc_pkg::DATA_BITS - total : 4;
      total = (total + term + 7) & ~7;
      pad = 8'hEC;
      for (int u = total >> 3; u < qrenc_pkg::DATA_BYTES; u++) begin
        text_bytes[u] = pad;
        pad = (pad == 8'hEC) ? 8'h11 : 8'hEC;
      end
      foreach (ecc[j]) ecc[j] = 0;
      for (int i = 0; i < qrenc_pkg::DATA_BYTES; i++) begin
        f = text_bytes[i] ^ ecc[0];
        for (int j = 0; j < qrenc_pkg::ECC_BYTES - 1; j++)
          ecc[j] = ecc[j + 1] ^ gf_times(qrenc_pkg::GEN[j], f);
        ecc[qrenc_pkg::ECC_BYTES - 1] =
          gf_times(qrenc_pkg::GEN[qrenc_pkg::ECC_BYTES - 1], f);
      end
      for (int i = 0; i < qrenc_pkg::DATA_BYTES; i++) cw[i] = text_bytes[i];
      for (int i = 0; i < qrenc_pkg::ECC_BYTES; i++) cw[qrenc_pkg::DATA_BYTES + i] = ecc[i];
      for (int r = 0; r < qrenc_pkg::SIDE; r++) begin
        grid[r] = qrenc_pkg::FIX_DARK[r];
        occ[r]  = qrenc_pkg::FIX_MAP[r];
      end
      idx = 0;
      right = qrenc_pkg::SIDE - 1;
      while (right >= 1) begin
        if (right == 6) right = 5;
        for (int v = 0; v < qrenc_pkg::SIDE; v++) begin
          y = (((right + 1) & 2) == 0) ? qrenc_pkg::SIDE - 1 - v : v;
          for (int k = 0; k < 2; k++) begin
            x = right - k;
            if (!occ[y][x] && idx < qrenc_pkg::CW_BITS) begin
              d = cw[idx >> 3][7 - (idx & 7)];
              idx++;
              if (((x + y) & 1) == 0) d = ~d;
              grid[y][x] = d;
            end
          end
        end
        right -= 2;
      end
      if (idx != qrenc_pkg::CW_BITS) bad = 1;
    end
    for (int r = 0; r < qrenc_pkg::SIDE; r++)
      row_q.push_back('{5'(r), bad ? 21'd0 : grid[r], !bad, r == qrenc_pkg::SIDE - 1});
    clear_text();
  endtask

  task automatic take_char(input logic [7:0] c, input logic has, input logic fin);
    int v;
    if (has && !bad) begin
      v = char_symbol(c);
      if (v < 0 || nchars >= qrenc_pkg::MAX_CHARS) bad = 1;
      else begin
        nchars++;
        if (pend_vld) begin
          push_group(pend_val * qrenc_pkg::ALNUM_BASE + v, 11);
          pend_vld = 0;
          pend_val = 0;
        end else begin
          pend_val = v;
          pend_vld = 1;
        end
      end
    end
    if (fin) emit_symbol();
  endtask

  always @(posedge clk_i) begin
    row_exp_t e;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_char(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (row_q.size() == 0) begin
          $error("row with no expectation: tdata %h", m_axis_tdata_i);
          fails++;
        end else begin
          e = row_q.pop_front();
          if (m_axis_tdata_i[4:0] !== e.idx) begin
            $error("row_index exp %0d got %0d", e.idx, m_axis_tdata_i[4:0]);
            fails++;
          end
          if (m_axis_tdata_i[25:5] !== e.bits) begin
            $error("row_bits exp %h got %h", e.bits, m_axis_tdata_i[25:5]);
            fails++;
          end
          if (m_axis_tuser_i !== e.ok) begin
            $error("ok exp %0b got %0b", e.ok, m_axis_tuser_i);
            fails++;
          end
          if (m_axis_tlast_i !== e.lst) begin
            $error("last_row exp %0b got %0b", e.lst, m_axis_tlast_i);
            fails++;
          end
        end
      end
    end
    pend_rows = row_q.size();
  end

endmodule

/* sim/qr_v1_alnum_symbol_encoder_core_tb.sv */
module qr_v1_alnum_symbol_encoder_core_tb;

  localparam int STALL_LIMIT = 12000;
  localparam int N_RANDOM    = 290;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 0;
  logic        s_axis_tuser_i = 0;
  logic        s_axis_tlast_i = 0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  int          fail_cnt, rows_pending, idle_cycles;
  logic        no_gaps = 0, hold_off = 0, done = 0;
  string       alnum_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

  qr_v1_alnum_symbol_encoder_core i_dut (.*);

  qr_v1_alnum_symbol_encoder_core_chk i_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i, .s_axis_tlast_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .m_axis_tlast_i(m_axis_tlast_o),
    .fail_cnt_o(fail_cnt), .rows_pending_o(rows_pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready_i <= 0;
      else m_axis_tready_i <= no_gaps || ($urandom_range(99) >= 35);
    end
  end

  task automatic send_req(input logic [7:0] c, input logic has, input logic fin);
    while (!no_gaps && $urandom_range(99) < 35) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i  <= c;
    s_axis_tuser_i  <= has;
    s_axis_tlast_i  <= fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic [7:0] good_char();
    return alnum_set[$urandom_range(alnum_set.len() - 1)];
  endfunction

  task automatic send_text(input int n, input logic noisy);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = good_char();
      if (noisy && $urandom_range(99) < 3) c = 8'($urandom_range(255));
      send_req(c, noisy ? ($urandom_range(19) != 0) : 1'b1, 1'b0);
    end
    send_req(good_char(), 1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty text, one char, max length, overlength, bad chars, all codes
    send_req(8'h00, 1'b0, 1'b1);
    send_req("A", 1'b1, 1'b1);
    send_req(":", 1'b1, 1'b0); send_req(8'hFF, 1'b0, 1'b1);
    for (int i = 0; i < 24; i++) send_req("Z", 1'b1, 1'b0);
    send_req("9", 1'b1, 1'b1);
    for (int i = 0; i < 25; i++) send_req(" ", 1'b1, 1'b0);
    send_req("0", 1'b1, 1'b1);
    send_req("a", 1'b1, 1'b0); send_req("B", 1'b1, 1'b1);
    send_req(8'h80, 1'b1, 1'b1);
    send_req(8'hFF, 1'b1, 1'b0); send_req(8'h00, 1'b1, 1'b1);
    for (int i = 0; i < alnum_set.len(); i++)
      send_req(alnum_set[i], 1'b1, (i % 11) == 10);
    send_req(8'h55, 1'b1, 1'b1);
    send_req(8'hAA, 1'b1, 1'b1);
    // long stall: receiver holds off while two texts keep coming
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        send_text(4, 0);
        send_text(6, 0);
      end
    join
    no_gaps = 1;
    send_text(10, 0);
    send_text(3, 0);
    no_gaps = 0;
    sent = 0;
    while (sent < N_RANDOM) begin
      int n;
      if ($urandom_range(9) == 0) n = $urandom_range(30);
      else n = $urandom_range(24);
      if ($urandom_range(9) < 8) send_text(n, 0);
      else send_text(n, 1);
      sent += n + 1;
    end
    s_axis_tvalid_i <= 0;
    repeat (2) @(posedge clk_i);
    wait (rows_pending == 0);
    repeat (600) @(posedge clk_i);
    done = 1;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else idle_cycles++;
      if (done) begin
        if (fail_cnt == 0 && rows_pending == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
      end else if (idle_cycles > STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
